// ----- rtl/core/sgen_pkg.sv -----
package sgen_pkg;

  // Input item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD_SLOWEST = 3'd0,
    REG_PERIOD_FASTEST = 3'd1,
    REG_DURATION_LOW   = 3'd2,
    REG_DURATION_HIGH  = 3'd3,
    REG_BLACKOUT_LOW   = 3'd4,
    REG_BLACKOUT_HIGH  = 3'd5,
    REG_FULL_ON_LOW    = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] RST_PERIOD_SLOWEST = 16'd1000;
  localparam logic [15:0] RST_PERIOD_FASTEST = 16'd50;
  localparam logic [7:0]  RST_DURATION_LOW   = 8'd11;
  localparam logic [7:0]  RST_DURATION_HIGH  = 8'd250;
  localparam logic [7:0]  RST_BLACKOUT_LOW   = 8'd0;
  localparam logic [7:0]  RST_BLACKOUT_HIGH  = 8'd10;
  localparam logic [7:0]  RST_FULL_ON_LOW    = 8'd251;

  localparam int TIME_BITS_DEF = 16;

  // Top of the speed channel, also the divisor of the period map
  localparam logic [7:0]  SPEED_FULL = 8'd255;
  localparam logic [15:0] PERIOD_MIN = 16'd2;

  // 2^32 / SPEED_FULL rounded up; exact quotient for any 24-bit dividend
  localparam int          SPEED_RECIP_SH = 32;
  localparam logic [24:0] SPEED_RECIP    = 25'd16843010;

  // Divider for the on-time map: 24-bit dividend, 8-bit divisor
  localparam int DIV_N = 24;
  localparam int DIV_D = 8;

  typedef struct packed {
    logic       kind;
    logic [7:0] dimmer;
    logic [7:0] speed;
    logic [7:0] duration_level;
  } item_in_t;

  typedef struct packed {
    logic [7:0] pwm_level;
    logic       light_lit;
  } item_out_t;

  typedef struct packed {
    logic mul1;
    logic div1_start;
    logic latch_period;
    logic mul2;
    logic div2_start;
    logic latch_times;
    logic apply;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_times;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/sgen_div.sv -----
module sgen_div #(
  parameter int N = 24,
  parameter int D = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient,
  output logic         done
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo;
  logic [D-1:0]     rem;
  logic [D-1:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D:0]       rem_sh;
  logic             ge;
  logic [D:0]       rem_sub;

  assign rem_sh   = {rem, quo[N-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= CNT_W'(N);
        busy <= 1'b1;
      end else if (busy) begin
        // one restoring step per cycle
        rem <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
        quo <= {quo[N-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/sgen_ctrl.sv -----
module sgen_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sgen_pkg::dp_status_t   status,
  output logic                   in_stall,
  output sgen_pkg::ctrl_cmd_t    cmd
);

  import sgen_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL1,
    S_DIV1,
    S_PERIOD,
    S_MUL2,
    S_DIV2,
    S_TIMES,
    S_APPLY,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
      cmd      <= '0;
    end else begin
      cmd <= '0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            state    <= S_DECIDE;
            in_stall <= 1'b1;
          end
        end
        S_DECIDE: begin
          if (status.need_times) begin
            state    <= S_MUL1;
            cmd.mul1 <= 1'b1;
          end else begin
            state     <= S_APPLY;
            cmd.apply <= 1'b1;
          end
        end
        S_MUL1: begin
          state          <= S_DIV1;
          cmd.div1_start <= 1'b1;
        end
        S_DIV1: begin
          // period quotient is registered at the end of this cycle
          state            <= S_PERIOD;
          cmd.latch_period <= 1'b1;
        end
        S_PERIOD: begin
          state    <= S_MUL2;
          cmd.mul2 <= 1'b1;
        end
        S_MUL2: begin
          state          <= S_DIV2;
          cmd.div2_start <= 1'b1;
        end
        S_DIV2: begin
          if (status.div_done) begin
            state           <= S_TIMES;
            cmd.latch_times <= 1'b1;
          end
        end
        S_TIMES: begin
          state     <= S_APPLY;
          cmd.apply <= 1'b1;
        end
        S_APPLY: begin
          state    <= S_EMIT;
          cmd.emit <= 1'b1;
        end
        S_EMIT: begin
          // hold the result until the output register frees up
          if (status.out_free) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end else begin
            cmd.emit <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sgen_datapath.sv -----
module sgen_datapath #(
  parameter int TIME_BITS = sgen_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [sgen_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sgen_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  sgen_pkg::item_in_t                  in_item,
  input  logic                                out_stall,
  input  sgen_pkg::ctrl_cmd_t                 cmd,
  output sgen_pkg::dp_status_t                status,
  output logic                                out_valid,
  output sgen_pkg::item_out_t                 out_item
);

  import sgen_pkg::*;

  localparam int SAT_W = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [SAT_W-1:0]     TMAX_W   = SAT_W'({TIME_BITS{1'b1}});
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  function automatic logic [TIME_BITS-1:0] sat_time(input logic [15:0] v);
    logic [SAT_W-1:0] w;
    begin
      w = SAT_W'(v);
      if (w > TMAX_W) w = TMAX_W;
      return TIME_BITS'(w);
    end
  endfunction

  // configuration
  logic [15:0] cfg_slow, cfg_fast;
  logic [7:0]  cfg_dur_low, cfg_dur_high, cfg_blk_low, cfg_blk_high, cfg_full_low;

  // item and timing math
  item_in_t       item;
  logic [23:0]    prod1, prod2;
  logic [48:0]    recip_prod;
  logic [15:0]    quo1;
  logic           neg1, neg2, bounds_eq;
  logic [7:0]     den2;
  logic [15:0]    period;
  logic           div_start;
  logic [23:0]    div_dividend;
  logic [7:0]     div_divisor;
  logic [23:0]    div_quo;
  logic           div_done;

  // strobe state
  logic                 started, phase_on;
  logic [7:0]           level_out;
  logic [TIME_BITS-1:0] on_ms, off_ms, since, target;
  logic [7:0]           held_dimmer, held_speed, held_duration;

  logic                 started_next, phase_next;
  logic [7:0]           level_next;
  logic [TIME_BITS-1:0] since_next, target_next, since_inc;
  logic [7:0]           held_dimmer_next, held_speed_next, held_duration_next;
  logic [7:0]           lvl_new;
  logic                 toggle;

  logic        fast_below;
  logic [15:0] speed_span;
  logic [16:0] per_sum;
  logic        dur_below, bound_below;
  logic [7:0]  dur_span, bound_span;
  logic [15:0] period_m2, on_calc, off_calc;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  assign status.need_times = (item.kind == KIND_FRAME) &&
                             (!started || (item.duration_level > cfg_blk_high &&
                                           item.duration_level < cfg_full_low));
  assign status.div_done   = div_done;
  assign status.out_free   = out_free;

  // period = slow + speed * (fast - slow) / 255, truncated toward zero
  assign fast_below = cfg_fast < cfg_slow;
  assign speed_span = fast_below ? cfg_slow - cfg_fast : cfg_fast - cfg_slow;
  // divide by 255 as a multiply by its scaled reciprocal
  assign recip_prod = {25'd0, prod1} * {24'd0, SPEED_RECIP};
  assign per_sum    = neg1 ? {1'b0, cfg_slow} - {1'b0, quo1}
                           : {1'b0, cfg_slow} + {1'b0, quo1};

  // on = 1 + (dur - dlo) * (period - 2) / (dhi - dlo)
  assign dur_below   = item.duration_level < cfg_dur_low;
  assign dur_span    = dur_below ? cfg_dur_low - item.duration_level
                                 : item.duration_level - cfg_dur_low;
  assign bound_below = cfg_dur_high < cfg_dur_low;
  assign bound_span  = bound_below ? cfg_dur_low - cfg_dur_high : cfg_dur_high - cfg_dur_low;
  assign period_m2   = period - PERIOD_MIN;

  always_comb begin
    if (bounds_eq || neg2) begin
      on_calc = 16'd1;
    end else if (div_quo > {8'd0, period_m2}) begin
      on_calc = period - 16'd1;
    end else begin
      on_calc = div_quo[15:0] + 16'd1;
    end
    off_calc = period - on_calc;
  end

  assign div_start    = cmd.div2_start;
  assign div_dividend = prod2;
  assign div_divisor  = den2;

  sgen_div #(
    .N (DIV_N),
    .D (DIV_D)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // per-item state update
  always_comb begin
    started_next       = started;
    phase_next         = phase_on;
    level_next         = level_out;
    since_next         = since;
    target_next        = target;
    held_dimmer_next   = held_dimmer;
    held_speed_next    = held_speed;
    held_duration_next = held_duration;
    since_inc          = (since != TIME_MAX) ? since + TIME_BITS'(1) : since;
    toggle             = 1'b0;
    if (item.kind == KIND_TICK) begin
      if (started) begin
        since_next = since_inc;
        toggle     = since_inc >= target;
      end
    end else begin
      held_dimmer_next   = item.dimmer;
      held_speed_next    = item.speed;
      held_duration_next = item.duration_level;
      if (!started) begin
        started_next = 1'b1;
        toggle       = 1'b1;
      end else if (item.speed != held_speed) begin
        // resync the running phase to the new times
        target_next = phase_on ? on_ms : off_ms;
        toggle      = since >= target_next;
      end
    end
    lvl_new = (held_duration_next >= cfg_blk_low && held_duration_next <= cfg_blk_high)
              ? 8'd0 : held_dimmer_next;
    if (toggle) begin
      phase_next  = !phase_on;
      level_next  = phase_on ? 8'd0 : lvl_new;
      target_next = phase_on ? off_ms : on_ms;
      since_next  = '0;
    end else if (item.kind == KIND_FRAME && started && phase_on &&
                 item.dimmer != held_dimmer) begin
      level_next = lvl_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_slow      <= RST_PERIOD_SLOWEST;
      cfg_fast      <= RST_PERIOD_FASTEST;
      cfg_dur_low   <= RST_DURATION_LOW;
      cfg_dur_high  <= RST_DURATION_HIGH;
      cfg_blk_low   <= RST_BLACKOUT_LOW;
      cfg_blk_high  <= RST_BLACKOUT_HIGH;
      cfg_full_low  <= RST_FULL_ON_LOW;
      started       <= 1'b0;
      phase_on      <= 1'b0;
      level_out     <= '0;
      on_ms         <= '0;
      off_ms        <= '0;
      since         <= '0;
      target        <= '0;
      held_dimmer   <= '0;
      held_speed    <= '0;
      held_duration <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PERIOD_SLOWEST: cfg_slow     <= cfg_data;
          REG_PERIOD_FASTEST: cfg_fast     <= cfg_data;
          REG_DURATION_LOW:   cfg_dur_low  <= cfg_data[7:0];
          REG_DURATION_HIGH:  cfg_dur_high <= cfg_data[7:0];
          REG_BLACKOUT_LOW:   cfg_blk_low  <= cfg_data[7:0];
          REG_BLACKOUT_HIGH:  cfg_blk_high <= cfg_data[7:0];
          REG_FULL_ON_LOW:    cfg_full_low <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.latch_times) begin
        on_ms  <= sat_time(on_calc);
        off_ms <= sat_time(off_calc);
      end
      if (cmd.apply) begin
        started       <= started_next;
        phase_on      <= phase_next;
        level_out     <= level_next;
        since         <= since_next;
        target        <= target_next;
        held_dimmer   <= held_dimmer_next;
        held_speed    <= held_speed_next;
        held_duration <= held_duration_next;
      end
      if (cmd.emit && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
    if (cmd.mul1) begin
      neg1  <= fast_below;
      prod1 <= {16'd0, item.speed} * {8'd0, speed_span};
    end
    if (cmd.div1_start) begin
      quo1 <= recip_prod[SPEED_RECIP_SH +: 16];
    end
    if (cmd.latch_period) begin
      period <= (per_sum[15:0] < PERIOD_MIN) ? PERIOD_MIN : per_sum[15:0];
    end
    if (cmd.mul2) begin
      neg2      <= dur_below ^ bound_below;
      bounds_eq <= cfg_dur_high == cfg_dur_low;
      den2      <= bound_span;
      prod2     <= {16'd0, dur_span} * {8'd0, period_m2};
    end
    if (cmd.emit && out_free) begin
      out_item.pwm_level <= level_out;
      out_item.light_lit <= phase_on;
    end
  end

`ifndef NO_ASSERTIONS
  a_started_sticky: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started dropped without reset");

  a_lit_needs_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> !phase_on)
    else $error("on phase before first frame");

  a_dark_level: assert property (@(posedge clk) disable iff (rst)
    !phase_on |-> level_out == 8'd0)
    else $error("nonzero level in off phase");
`endif

endmodule

// ----- rtl/core/strobe_timing_generator_core.sv -----
// Strobe timing generator.
// Input channel (in_valid / in_stall / in_item): each transfer is either a
// 1 ms tick or a control frame (dimmer, speed, duration). Every input gives
// exactly one result on the output channel (out_valid / out_stall / out_item):
// the PWM level and whether the strobe is in its on phase.
// Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) set the
// period range, duration window, blackout window and full-on threshold;
// cfg_ready is always high. Write only while no item is in flight.
// One item is in work at a time. A tick, or a frame that leaves the times
// alone, goes through the decide, apply and emit states before the next
// transfer can be taken, and out_valid rises from the emit state. A frame
// that remaps the times also runs the period map and the on-time map; its
// time is set mostly by the radix-2 divider for the on-time map, while the
// period map divides by 255 through a reciprocal multiply.
// The output register holds a result while out_stall is high; the next item is
// still taken and worked on, and waits only when its own result is ready.
// Synchronous reset loads the default register values, clears the strobe state
// (not started, off, level 0) and empties the output register.
module strobe_timing_generator_core #(
  parameter int TIME_BITS = sgen_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgen_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sgen_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sgen_pkg::item_in_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sgen_pkg::item_out_t               out_item
);

  import sgen_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sgen_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sgen_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
